@@ rtl/four_pole_ladder_filter_defines.svh @@
// Assertion macros shared by the checker.
// They expect signals named clk and rst_n in the scope of use.
`ifndef FOUR_POLE_LADDER_FILTER_DEFINES_SVH
`define FOUR_POLE_LADDER_FILTER_DEFINES_SVH

// Next-cycle implication, ignored while reset is low.
`define FPL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define FPL_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fpl_pkg.sv @@
package fpl_pkg;

  localparam int NUM_STAGES = 4;
  localparam int NUM_TAPS   = NUM_STAGES + 1;
  localparam int MODE_COUNT = 15;

  typedef logic signed [23:0] sample_t;
  typedef logic signed [23:0] coef_t;
  typedef logic signed [31:0] tap_t;
  typedef logic [3:0]         mode_t;
  typedef logic [2:0]         reg_idx_t;
  typedef logic signed [4:0]  weight_t;

  // register indexes
  localparam reg_idx_t REG_POLE_COEF     = 3'd0;
  localparam reg_idx_t REG_STAGE_GAIN    = 3'd1;
  localparam reg_idx_t REG_FEEDBACK_GAIN = 3'd2;
  localparam reg_idx_t REG_OUTPUT_GAIN   = 3'd3;
  localparam reg_idx_t REG_FILTER_MODE   = 3'd4;

  localparam coef_t RST_POLE_COEF     = -24'sd917890;
  localparam coef_t RST_STAGE_GAIN    = 24'sd130686;
  localparam coef_t RST_FEEDBACK_GAIN = 24'sd0;
  localparam coef_t RST_OUTPUT_GAIN   = 24'sd1048576;
  localparam mode_t RST_FILTER_MODE   = 4'd4;
  localparam mode_t MODE_RESERVED     = 4'd15;

  // multiplier operand A selects
  localparam logic [2:0] A_Y0  = 3'd0;
  localparam logic [2:0] A_Y1  = 3'd1;
  localparam logic [2:0] A_Y2  = 3'd2;
  localparam logic [2:0] A_Y3  = 3'd3;
  localparam logic [2:0] A_Y4  = 3'd4;
  localparam logic [2:0] A_SQ  = 3'd5;
  localparam logic [2:0] A_MLO = 3'd6;
  localparam logic [2:0] A_MHI = 3'd7;

  // multiplier operand B selects
  localparam logic [2:0] B_POLE = 3'd0;
  localparam logic [2:0] B_STG  = 3'd1;
  localparam logic [2:0] B_FB   = 3'd2;
  localparam logic [2:0] B_OUT  = 3'd3;
  localparam logic [2:0] B_WGT  = 3'd4;
  localparam logic [2:0] B_Y4   = 3'd5;

  // accumulator operations on the registered product
  localparam logic [2:0] ACC_HOLD  = 3'd0;
  localparam logic [2:0] ACC_LD    = 3'd1;
  localparam logic [2:0] ACC_ADD   = 3'd2;
  localparam logic [2:0] ACC_SUB   = 3'd3;
  localparam logic [2:0] ACC_LDX   = 3'd4;
  localparam logic [2:0] ACC_ADDSH = 3'd5;

  // writeback targets
  localparam logic [2:0] WB_Y0   = 3'd0;
  localparam logic [2:0] WB_Y1   = 3'd1;
  localparam logic [2:0] WB_Y2   = 3'd2;
  localparam logic [2:0] WB_Y3   = 3'd3;
  localparam logic [2:0] WB_Y4   = 3'd4;
  localparam logic [2:0] WB_OUT  = 3'd5;
  localparam logic [2:0] WB_NONE = 3'd7;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [2:0] acc_op;
    logic [2:0] wb_sel;
    logic       div_start;
  } fpl_ctl_t;

  // tap mixing weights per mode
  localparam weight_t MIX_W [MODE_COUNT][NUM_TAPS] = '{
    '{ 5'sd1,  5'sd0,   5'sd0,   5'sd0,  5'sd0 },
    '{ 5'sd0,  5'sd1,   5'sd0,   5'sd0,  5'sd0 },
    '{ 5'sd0,  5'sd0,   5'sd1,   5'sd0,  5'sd0 },
    '{ 5'sd0,  5'sd0,   5'sd0,   5'sd1,  5'sd0 },
    '{ 5'sd0,  5'sd0,   5'sd0,   5'sd0,  5'sd1 },
    '{ 5'sd1, -5'sd1,   5'sd0,   5'sd0,  5'sd0 },
    '{ 5'sd1, -5'sd2,   5'sd1,   5'sd0,  5'sd0 },
    '{ 5'sd1, -5'sd3,   5'sd3,  -5'sd1,  5'sd0 },
    '{ 5'sd1, -5'sd4,   5'sd6,  -5'sd4,  5'sd1 },
    '{ 5'sd0,  5'sd2,  -5'sd2,   5'sd0,  5'sd0 },
    '{ 5'sd0,  5'sd0,   5'sd3,  -5'sd3,  5'sd0 },
    '{ 5'sd0,  5'sd0,   5'sd0,   5'sd4, -5'sd4 },
    '{ 5'sd0,  5'sd3,  -5'sd6,   5'sd3,  5'sd0 },
    '{ 5'sd0,  5'sd0,   5'sd4,  -5'sd8,  5'sd4 },
    '{ 5'sd0,  5'sd4, -5'sd12,  5'sd12, -5'sd4 }
  };

endpackage

@@ rtl/fpl_ifs.sv @@
interface fpl_sample_in_if;
  import fpl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface fpl_sample_out_if;
  import fpl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface fpl_cfg_if;
  import fpl_pkg::*;
  logic     valid;
  logic     ready;
  reg_idx_t reg_index;
  coef_t    wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/fpl_mul.sv @@
module fpl_mul (
  input  logic                clk,
  input  logic signed [32:0]  a,
  input  logic signed [32:0]  b,
  output logic signed [65:0]  prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end
endmodule

@@ rtl/fpl_div.sv @@
// Restoring divider: (num * 2^24) / den, num < den, truncated toward zero.
module fpl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        num,
  input  logic [38:0]        den,
  input  logic               neg,
  output logic               busy,
  output logic signed [24:0] quo
);
  localparam int QBITS = 24;

  logic [38:0] rem_r, rem_nxt;
  logic [38:0] den_r;
  logic [QBITS-1:0] q_r, q_nxt;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic        busy_r;
  logic [39:0] shifted;
  logic        fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    rem_nxt = fits ? 39'(shifted - {1'b0, den_r}) : shifted[38:0];
    q_nxt   = {q_r[QBITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(QBITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 39'(num);
      den_r <= den;
      q_r   <= '0;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule

@@ rtl/fpl_seq.sv @@
// Microprogram sequencer: one step per cycle, holding while the divider is busy
// or the output stalls; a product lands in the step after its operands issue.
module fpl_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                div_busy,
  input  logic                out_stall,
  output logic                busy,
  output fpl_pkg::fpl_ctl_t   ctl
);
  import fpl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [4:0] STEP_DIV_WAIT = 5'd2;
  localparam logic [4:0] STEP_LAST     = 5'd31;

  logic       state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       advance;

  always_comb begin
    ctl       = '{a_sel: A_Y0, b_sel: B_POLE, acc_op: ACC_HOLD,
                  wb_sel: WB_NONE, div_start: 1'b0};
    advance   = 1'b1;
    if (state_r == ST_RUN) begin
      case (step_r)
        5'd0:  begin ctl.a_sel = A_Y4; ctl.b_sel = B_Y4; end
        5'd1:  ctl.div_start = 1'b1;
        STEP_DIV_WAIT: advance = !div_busy;
        5'd3:  begin ctl.a_sel = A_SQ; ctl.b_sel = B_FB; end
        5'd4:  ctl.acc_op = ACC_LDX;
        5'd5:  ctl.wb_sel = WB_Y0;
        5'd6:  begin ctl.a_sel = A_Y0; ctl.b_sel = B_STG; end
        5'd7:  begin ctl.a_sel = A_Y1; ctl.b_sel = B_POLE; ctl.acc_op = ACC_LD; end
        5'd8:  ctl.acc_op = ACC_SUB;
        5'd9:  ctl.wb_sel = WB_Y1;
        5'd10: begin ctl.a_sel = A_Y1; ctl.b_sel = B_STG; end
        5'd11: begin ctl.a_sel = A_Y2; ctl.b_sel = B_POLE; ctl.acc_op = ACC_LD; end
        5'd12: ctl.acc_op = ACC_SUB;
        5'd13: ctl.wb_sel = WB_Y2;
        5'd14: begin ctl.a_sel = A_Y2; ctl.b_sel = B_STG; end
        5'd15: begin ctl.a_sel = A_Y3; ctl.b_sel = B_POLE; ctl.acc_op = ACC_LD; end
        5'd16: ctl.acc_op = ACC_SUB;
        5'd17: ctl.wb_sel = WB_Y3;
        5'd18: begin ctl.a_sel = A_Y3; ctl.b_sel = B_STG; end
        // last stage feeds back its squashed old value
        5'd19: begin ctl.a_sel = A_SQ; ctl.b_sel = B_POLE; ctl.acc_op = ACC_LD; end
        5'd20: ctl.acc_op = ACC_SUB;
        5'd21: ctl.wb_sel = WB_Y4;
        5'd22: begin ctl.a_sel = A_Y0; ctl.b_sel = B_WGT; end
        5'd23: begin ctl.a_sel = A_Y1; ctl.b_sel = B_WGT; ctl.acc_op = ACC_LD; end
        5'd24: begin ctl.a_sel = A_Y2; ctl.b_sel = B_WGT; ctl.acc_op = ACC_ADD; end
        5'd25: begin ctl.a_sel = A_Y3; ctl.b_sel = B_WGT; ctl.acc_op = ACC_ADD; end
        5'd26: begin ctl.a_sel = A_Y4; ctl.b_sel = B_WGT; ctl.acc_op = ACC_ADD; end
        5'd27: ctl.acc_op = ACC_ADD;
        5'd28: begin ctl.a_sel = A_MLO; ctl.b_sel = B_OUT; end
        5'd29: begin ctl.a_sel = A_MHI; ctl.b_sel = B_OUT; ctl.acc_op = ACC_LD; end
        5'd30: ctl.acc_op = ACC_ADDSH;
        5'd31: begin
          advance    = !out_stall;
          ctl.wb_sel = out_stall ? WB_NONE : WB_OUT;
        end
        default: ctl.wb_sel = WB_NONE;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (step_r == STEP_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 5'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r == ST_RUN);
endmodule

@@ rtl/four_pole_ladder_filter.sv @@
// Channel  Dir  Payload                          Transfer when
// in_ch    in   sample_in  (Q1.23)               in_ch.valid & in_ch.ready
// out_ch   out  sample_out (Q1.23, saturated)    out_ch.valid & out_ch.ready
// cfg_ch   in   reg_index, wdata                 cfg_ch.valid & cfg_ch.ready
//
// A sample is taken only while the sequencer is idle: two steps square y4 and
// start the divider, the sequencer waits on its 24 restoring iterations, then
// 29 steps run through the single 33x33 multiplier and its accumulator.
// rst_n (synchronous) clears the taps, the sequencer and loads the default
// coefficients. A result waits in the output register; the next sample is
// taken meanwhile and only its final write stalls until out_ch drains.
// cfg_ch is always ready.
module four_pole_ladder_filter (
  input  logic              clk,
  input  logic              rst_n,
  fpl_sample_in_if.sink     in_ch,
  fpl_sample_out_if.source  out_ch,
  fpl_cfg_if.sink           cfg_ch
);
  import fpl_pkg::*;

  // configuration registers
  coef_t pole_coef_r;
  coef_t stage_gain_r;
  coef_t feedback_gain_r;
  coef_t output_gain_r;
  mode_t filter_mode_r;

  // filter state and working registers
  tap_t                 y_r [NUM_TAPS];
  sample_t              x_r;
  logic signed [63:0]   acc_r, acc_nxt;
  sample_t              out_data_r;
  logic                 out_valid_r;

  fpl_ctl_t             ctl;
  logic                 seq_busy;
  logic                 div_busy;
  logic signed [24:0]   squash;
  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   prod_r;
  logic signed [63:0]   prod;
  logic [31:0]          y4_mag;
  logic [38:0]          den;
  weight_t              tap_weight;
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 out_stall;
  tap_t                 wb_tap;
  sample_t              wb_out;

  // round half up by 2^20, clamp to 32 bits
  function automatic tap_t sat_rnd20(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 19)) >>> 20;
    if (r > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  // round half up by 2^21, clamp to 24 bits
  function automatic sample_t sat_rnd21(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 20)) >>> 21;
    if (r > 64'sd8388607) begin
      return 24'sh7fffff;
    end else if (r < -64'sd8388608) begin
      return 24'sh800000;
    end
    return r[23:0];
  endfunction

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_valid_r && out_ch.ready;
  assign out_stall = out_valid_r && !out_ch.ready;

  assign in_ch.ready       = !seq_busy;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;
  assign cfg_ch.ready      = 1'b1;

  fpl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .div_busy  (div_busy),
    .out_stall (out_stall),
    .busy      (seq_busy),
    .ctl       (ctl)
  );

  // squash divisor: 2^24 + floor(y4^2 / 2^24), product of step 0
  assign y4_mag = y_r[NUM_STAGES][31] ? (~y_r[NUM_STAGES] + 32'd1) : y_r[NUM_STAGES];
  assign den    = prod_r[62:24] + 39'h1000000;

  fpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (y4_mag),
    .den   (den),
    .neg   (y_r[NUM_STAGES][31]),
    .busy  (div_busy),
    .quo   (squash)
  );

  // weight of the tap on operand A; only read for the tap selects
  always_comb begin
    tap_weight = '0;
    if (ctl.a_sel <= A_Y4) begin
      tap_weight = MIX_W[filter_mode_r][ctl.a_sel];
    end
  end

  always_comb begin
    case (ctl.a_sel)
      A_Y0:    mul_a = 33'(y_r[0]);
      A_Y1:    mul_a = 33'(y_r[1]);
      A_Y2:    mul_a = 33'(y_r[2]);
      A_Y3:    mul_a = 33'(y_r[3]);
      A_Y4:    mul_a = 33'(y_r[4]);
      A_SQ:    mul_a = 33'(squash);
      // mix split: low 19 bits unsigned, bits 37:19 signed
      A_MLO:   mul_a = $signed({14'd0, acc_r[18:0]});
      A_MHI:   mul_a = 33'($signed(acc_r[37:19]));
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      B_POLE:  mul_b = 33'(pole_coef_r);
      B_STG:   mul_b = 33'(stage_gain_r);
      B_FB:    mul_b = 33'(feedback_gain_r);
      B_OUT:   mul_b = 33'(output_gain_r);
      B_WGT:   mul_b = 33'(tap_weight);
      B_Y4:    mul_b = 33'(y_r[4]);
      default: mul_b = '0;
    endcase
  end

  fpl_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign prod = $signed(prod_r[63:0]);

  always_comb begin
    case (ctl.acc_op)
      ACC_HOLD:  acc_nxt = acc_r;
      ACC_LD:    acc_nxt = prod;
      ACC_ADD:   acc_nxt = acc_r + prod;
      ACC_SUB:   acc_nxt = acc_r - prod;
      // input tap: sample_in * 2^21 - k * s
      ACC_LDX:   acc_nxt = (64'(x_r) <<< 21) - prod;
      ACC_ADDSH: acc_nxt = acc_r + (prod <<< 19);
      default:   acc_nxt = acc_r;
    endcase
  end

  assign wb_tap = sat_rnd20(acc_r);
  assign wb_out = sat_rnd21(acc_r);

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (in_xfer) begin
      x_r <= in_ch.sample_in;
    end
    if (ctl.wb_sel == WB_OUT) begin
      out_data_r <= wb_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        y_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        if (ctl.wb_sel == 3'(i)) begin
          y_r[i] <= wb_tap;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.wb_sel == WB_OUT) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // config writes; a mode code of fifteen leaves the mode as it is
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_coef_r     <= RST_POLE_COEF;
      stage_gain_r    <= RST_STAGE_GAIN;
      feedback_gain_r <= RST_FEEDBACK_GAIN;
      output_gain_r   <= RST_OUTPUT_GAIN;
      filter_mode_r   <= RST_FILTER_MODE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.reg_index)
        REG_POLE_COEF:     pole_coef_r     <= cfg_ch.wdata;
        REG_STAGE_GAIN:    stage_gain_r    <= cfg_ch.wdata;
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_ch.wdata;
        REG_OUTPUT_GAIN:   output_gain_r   <= cfg_ch.wdata;
        REG_FILTER_MODE: begin
          if (cfg_ch.wdata[3:0] != MODE_RESERVED) begin
            filter_mode_r <= cfg_ch.wdata[3:0];
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/fpl_checker.sv @@
`include "four_pole_ladder_filter_defines.svh"

module fpl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fpl_pkg::sample_t    out_data
);
  import fpl_pkg::*;

  `FPL_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready right after a transfer")
  `FPL_ASSERT_NXT(a_idle_holds, in_ready && !in_valid, in_ready, "dropped ready while idle")
  `FPL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `FPL_ASSERT_RST(a_rst_out, !rst_n, !out_valid, "result valid after reset")
endmodule

bind four_pole_ladder_filter fpl_checker u_fpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_out)
);
